// File: rtl/svl_pkg.sv
// Shared types, codes and widths for the sorted value list.
package svl_pkg;

   // Default number of stored values
   localparam int CAPACITY_DEF = 64;

   // Fixed field widths
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   // Packed stream widths (whole bytes)
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   // Command broadcast to every cell in the update cycle
   typedef struct packed {
      logic               shr;        // open a slot, move entries up
      logic               shl;        // close a slot, move entries down
      logic [VALUE_W-1:0] ins_value;  // value written into the opened slot
   } cell_cmd_type;

endpackage

// File: rtl/sorted_value_list_core.sv
// Top level of the sorted value list: sequencer, cell chain and result register.
//
//   channel | dir | handshake          | payload (low bit first)
//   --------+-----+--------------------+----------------------------------------
//   req     | in  | req_tvalid/tready  | kind[1:0] value[33:2], pad to 40 bits
//   rsp     | out | rsp_tvalid/tready  | status[1:0] position[7:2] count[14:8]
//
// For each item the accept cycle compares the value in every cell at once and
// registers the flags; the update cycle then encodes the boundary position and shifts the chain.
// The update cycle waits while a previous result still sits in the output register.
// Reset clears the count, the sequencer and the result valid flag; cell contents stay undefined.
// One item is in flight at a time; req_tready is high only between items.
module sorted_value_list_core
   import svl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // kind[1:0], value[33:2], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // status[1:0], position[7:2], count[14:8]
);

   localparam int CW = $clog2(CAPACITY+1);

   state_type                 state_ff, state_in;
   logic [KIND_W-1:0]         kind_ff;
   logic [VALUE_W-1:0]        value_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;

   logic                      accept;
   logic                      go;
   logic [KIND_W-1:0]         req_kind;
   logic signed [VALUE_W-1:0] req_value;
   cell_cmd_type              cmd;
   logic [VALUE_W-1:0]        cell_value [CAPACITY];
   logic [CAPACITY-1:0]       cell_lt;
   logic [CAPACITY-1:0]       cell_eq;
   logic [CW-1:0]             pos;
   logic                      found;
   logic [STATUS_W-1:0]       status;
   logic [CW-1:0]             res_pos;
   logic [CW+POS_W-1:0]       pos_ext;
   logic [CW+COUNT_W-1:0]     count_ext;
   logic                      full;
   logic                      empty;

   // Unpack the request
   assign req_kind  = req_tdata[KIND_W-1:0];
   assign req_value = $signed(req_tdata[KIND_W+VALUE_W-1:KIND_W]);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign go         = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);

   // Cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_value;
      logic               left_lt;
      logic [VALUE_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = value_ff;
         assign left_lt    = 1'b1;
      end else begin : g_inner
         assign left_value = cell_value[g-1];
         assign left_lt    = cell_lt[g-1];
      end

      if (g == CAPACITY-1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_body
         assign right_value = cell_value[g+1];
      end

      svl_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (g)
      ) u_cell (
         .clock       (clock),
         .cmp_en      (accept),
         .cmp_value   (req_value),
         .count       (count_ff),
         .cmd         (cmd),
         .left_value  (left_value),
         .left_lt     (left_lt),
         .right_value (right_value),
         .value       (cell_value[g]),
         .lt          (cell_lt[g]),
         .eq          (cell_eq[g])
      );
   end

   svl_pos_enc #(
      .CAPACITY (CAPACITY)
   ) u_pos_enc (
      .lt    (cell_lt),
      .eq    (cell_eq),
      .pos   (pos),
      .found (found)
   );

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);

   // Decide the outcome and the chain command for the update cycle
   always_comb begin
      cmd.shr       = 1'b0;
      cmd.shl       = 1'b0;
      cmd.ins_value = value_ff;
      status        = ST_OK;
      res_pos       = '0;
      count_in      = count_ff;
      if (kind_ff == KIND_INSERT) begin
         if (full) begin
            status = ST_FULL;
         end else begin
            res_pos  = pos;
            cmd.shr  = go;
            count_in = count_ff + CW'(1);
         end
      end else if (empty) begin
         status = ST_EMPTY;
      end else if (!found) begin
         status = ST_NOT_FOUND;
      end else begin
         res_pos = pos;
         if (kind_ff == KIND_DELETE) begin
            cmd.shl  = go;
            count_in = count_ff - CW'(1);
         end
      end
   end

   // Positions and counts wrap to their field widths
   assign pos_ext   = {{POS_W{1'b0}}, res_pos};
   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            count_ff <= count_in;
         end
      end
   end

   // Capture the item and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
      if (go) begin
         rsp_data_ff <= {1'b0, count_ext[COUNT_W-1:0], pos_ext[POS_W-1:0], status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/svl_cell.sv
// One storage cell of the sorted chain: holds an entry and its compare flags.
module svl_cell
   import svl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int INDEX    = 0
) (
   input  logic                                   clock,
   input  logic                                   cmp_en,
   input  logic signed [VALUE_W-1:0]              cmp_value,
   input  logic [$clog2(CAPACITY+1)-1:0]          count,
   input  cell_cmd_type                           cmd,
   input  logic [VALUE_W-1:0]                     left_value,
   input  logic                                   left_lt,
   input  logic [VALUE_W-1:0]                     right_value,
   output logic [VALUE_W-1:0]                     value,
   output logic                                   lt,
   output logic                                   eq
);

   localparam int CW = $clog2(CAPACITY+1);

   logic [VALUE_W-1:0] value_ff;
   logic               lt_ff;
   logic               eq_ff;
   logic               occupied;

   assign occupied = CW'(INDEX) < count;

   // Compare the stored entry against the incoming item
   always_ff @(posedge clock) begin
      if (cmp_en) begin
         lt_ff <= occupied && ($signed(value_ff) < cmp_value);
         eq_ff <= occupied && ($signed(value_ff) == cmp_value);
      end
   end

   // Shift entries at or above the boundary; on insert the boundary cell takes the new value
   always_ff @(posedge clock) begin
      if (cmd.shr && !lt_ff) begin
         value_ff <= left_lt ? cmd.ins_value : left_value;
      end else if (cmd.shl && !lt_ff) begin
         value_ff <= right_value;
      end
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// File: rtl/svl_pos_enc.sv
// Boundary encoder: turns the less-than flags of the chain into a position.
module svl_pos_enc
   import svl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic [CAPACITY-1:0]           lt,
   input  logic [CAPACITY-1:0]           eq,
   output logic [$clog2(CAPACITY+1)-1:0] pos,
   output logic                          found
);

   localparam int CW = $clog2(CAPACITY+1);

   logic [CAPACITY-1:0] lt_prev;
   logic [CAPACITY-1:0] bnd;

   // The chain is sorted, so less-than flags form a prefix; its end is one-hot
   assign lt_prev = {lt[CAPACITY-2:0], 1'b1};
   assign bnd     = ~lt & lt_prev;

   always_comb begin
      pos   = '0;
      found = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (bnd[i]) begin
            pos = pos | CW'(i);
         end
         found = found | (bnd[i] & eq[i]);
      end
      // every stored value smaller: boundary sits past the last cell
      if (lt[CAPACITY-1]) begin
         pos = CW'(CAPACITY);
      end
   end

endmodule

// File: rtl/svl_checker.sv
// Port-level checks for the sorted value list, bound to the top level.
module svl_checker
   import svl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One item at a time: no accept in the cycle after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted during update");

   // A failed operation reports position zero
   a_err_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_OK) |-> rsp_tdata[7:2] == '0)
      else $error("nonzero position on error status");

   // The count never passes the capacity
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (CAPACITY < 128) |-> rsp_tdata[14:8] <= 7'(CAPACITY))
      else $error("count above capacity");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind sorted_value_list_core svl_checker #(.CAPACITY(CAPACITY)) u_svl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
